### rtl/core/tcsf_pkg.sv
// ----------------------------------------------------------------------------
// tcsf_pkg
// Shared types and byte constants for the text stream filter core.
// ----------------------------------------------------------------------------
package tcsf_pkg;

	// input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_file;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// option registers
	typedef struct packed {
		logic number_nonblank;
		logic number_all;
		logic squeeze_blank;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	// register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SHOW_TABS        = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

	// byte codes
	localparam logic [7:0] NL_BYTE      = 8'h0A;
	localparam logic [7:0] TAB_BYTE     = 8'h09;
	localparam logic [7:0] DEL_BYTE     = 8'h7F;
	localparam logic [7:0] LOW7_MASK    = 8'h7F;
	localparam logic [7:0] CTRL_LIMIT   = 8'h20;
	localparam logic [7:0] CARET_OFFSET = 8'd64;
	localparam logic [7:0] CHAR_CARET   = 8'h5E;
	localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
	localparam logic [7:0] CHAR_M       = 8'h4D;
	localparam logic [7:0] CHAR_DASH    = 8'h2D;
	localparam logic [7:0] CHAR_I       = 8'h49;
	localparam logic [7:0] CHAR_QMARK   = 8'h3F;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// emitted byte history saturates here
	localparam logic [1:0] EMIT_SAT = 2'd2;

	// work descriptor handed from the classifier to the emitter
	typedef struct packed {
		logic       do_num;
		logic       m_pfx;
		logic       caret;
		logic       dollar;
		logic [7:0] final_byte;
	} job_t;

	// emitter phases, in output order
	typedef enum logic [2:0] {
		PH_DIGIT,
		PH_TAB,
		PH_M,
		PH_DASH,
		PH_CARET,
		PH_DOLLAR,
		PH_FINAL
	} phase_t;

endpackage

### rtl/core/tcsf_front.sv
// ----------------------------------------------------------------------------
// tcsf_front
// Classifier: applies squeeze, decides numbering, rewrites the byte and keeps
// the line counter and newline history. Produces one job per kept byte.
// ----------------------------------------------------------------------------
module tcsf_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcsf_pkg::cfg_t               cfg,
	input  tcsf_pkg::in_item_t           item,
	input  logic                         accept,
	output logic                         job_push,
	output tcsf_pkg::job_t               job,
	output logic [4*NUMBER_DIGITS-1:0]   job_bcd
);

	localparam int CW = 4 * NUMBER_DIGITS;
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);
	localparam logic [CW-1:0] ALL_NINES = {NUMBER_DIGITS{4'h9}};

	logic [CW-1:0] cnt_q;
	logic          prev_nl_q;
	logic          prev2_nl_q;
	logic [1:0]    emit_cnt_q;

	logic [CW-1:0] cnt_eff;
	logic [CW-1:0] cnt_inc;
	logic          pn;
	logic          pn2;
	logic [1:0]    ec;
	logic          is_nl;
	logic          drop;
	logic          line_start;
	logic          do_num;
	logic          m_pfx;
	logic          caret;
	logic          dollar;
	logic [7:0]    c_byte;

	// history as seen by this byte, cleared at file start
	always_comb begin
		cnt_eff = item.first_of_file ? CNT_ONE : cnt_q;
		pn      = item.first_of_file ? 1'b0 : prev_nl_q;
		pn2     = item.first_of_file ? 1'b0 : prev2_nl_q;
		ec      = item.first_of_file ? 2'd0 : emit_cnt_q;
	end

	// squeeze and numbering decisions
	always_comb begin
		is_nl      = (item.data_byte == tcsf_pkg::NL_BYTE);
		drop       = cfg.squeeze_blank && is_nl && pn &&
		             ((ec == 2'd1) || ((ec == tcsf_pkg::EMIT_SAT) && pn2));
		line_start = (ec == 2'd0) || pn;
		if (cfg.number_nonblank) begin
			do_num = line_start && !is_nl;
		end else begin
			do_num = cfg.number_all && line_start;
		end
	end

	// saturating bcd increment, ripple over digits
	always_comb begin
		logic       carry;
		logic [3:0] dig;
		carry   = 1'b1;
		cnt_inc = cnt_eff;
		for (int d = 0; d < NUMBER_DIGITS; d++) begin
			dig = cnt_eff[4*d +: 4];
			if (carry) begin
				if (dig == 4'd9) begin
					cnt_inc[4*d +: 4] = 4'd0;
				end else begin
					cnt_inc[4*d +: 4] = dig + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (cnt_eff == ALL_NINES) begin
			cnt_inc = cnt_eff;
		end
	end

	// byte rewrite: meta prefix, caret notation, end mark, tab notation
	always_comb begin
		c_byte = item.data_byte;
		m_pfx  = 1'b0;
		caret  = 1'b0;
		if (cfg.show_nonprinting && (c_byte != tcsf_pkg::NL_BYTE) &&
		    (c_byte != tcsf_pkg::TAB_BYTE)) begin
			if (c_byte[7]) begin
				m_pfx  = 1'b1;
				c_byte = c_byte & tcsf_pkg::LOW7_MASK;
			end
			if (c_byte < tcsf_pkg::CTRL_LIMIT) begin
				caret  = 1'b1;
				c_byte = c_byte + tcsf_pkg::CARET_OFFSET;
			end else if (c_byte == tcsf_pkg::DEL_BYTE) begin
				caret  = 1'b1;
				c_byte = tcsf_pkg::CHAR_QMARK;
			end
		end
		dollar = cfg.show_ends && (c_byte == tcsf_pkg::NL_BYTE);
		if (cfg.show_tabs && (c_byte == tcsf_pkg::TAB_BYTE)) begin
			caret  = 1'b1;
			c_byte = tcsf_pkg::CHAR_I;
		end
	end

	// job toward the queue
	always_comb begin
		job_push       = accept && !drop;
		job.do_num     = do_num;
		job.m_pfx      = m_pfx;
		job.caret      = caret;
		job.dollar     = dollar;
		job.final_byte = c_byte;
		job_bcd        = cnt_eff;
	end

	// counter and history update on each kept byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= CNT_ONE;
			prev_nl_q  <= 1'b0;
			prev2_nl_q <= 1'b0;
			emit_cnt_q <= 2'd0;
		end else if (job_push) begin
			cnt_q      <= do_num ? cnt_inc : cnt_eff;
			prev2_nl_q <= pn;
			prev_nl_q  <= is_nl;
			emit_cnt_q <= (ec == tcsf_pkg::EMIT_SAT) ? ec : ec + 2'd1;
		end
	end

endmodule

### rtl/core/tcsf_queue.sv
// ----------------------------------------------------------------------------
// tcsf_queue
// Short first-in first-out queue of jobs between classifier and emitter.
// ----------------------------------------------------------------------------
module tcsf_queue #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             q_empty,
	output logic             q_full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign rd_data = entry_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == NW'(DEPTH));

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + NW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

### rtl/core/tcsf_back.sv
// ----------------------------------------------------------------------------
// tcsf_back
// Emitter: walks the job at the queue head one output byte per cycle while its
// output register is free or popped, and holds the waiting result there.
// ----------------------------------------------------------------------------
module tcsf_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	input  tcsf_pkg::job_t             job,
	input  logic [4*NUMBER_DIGITS-1:0] job_bcd,
	output logic                       job_pop,
	input  logic                       pop,
	output logic                       empty,
	output tcsf_pkg::out_item_t        result
);

	localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
	localparam logic [DW-1:0] DIG_LAST = DW'(NUMBER_DIGITS - 1);

	tcsf_pkg::phase_t    phase_q;
	tcsf_pkg::phase_t    phase_d;
	tcsf_pkg::phase_t    ph;
	logic [DW-1:0]       digit_q;
	logic [DW-1:0]       digit_d;
	logic                seen_q;
	logic                seen_d;
	logic                out_valid_q;
	tcsf_pkg::out_item_t out_q;
	tcsf_pkg::out_item_t out_d;
	logic                advance;
	logic [3:0]          dig;
	logic                last_digit;

	assign advance    = job_valid && (!out_valid_q || pop);
	assign last_digit = (digit_q == DIG_LAST);
	assign dig        = job_bcd[(NUMBER_DIGITS - 1 - int'(digit_q)) * 4 +: 4];

	// skip phases the job does not use
	always_comb begin
		ph = phase_q;
		if ((ph == tcsf_pkg::PH_DIGIT) && !job.do_num) begin
			ph = tcsf_pkg::PH_M;
		end
		if ((ph == tcsf_pkg::PH_M) && !job.m_pfx) begin
			ph = tcsf_pkg::PH_CARET;
		end
		if ((ph == tcsf_pkg::PH_CARET) && !job.caret) begin
			ph = tcsf_pkg::PH_DOLLAR;
		end
		if ((ph == tcsf_pkg::PH_DOLLAR) && !job.dollar) begin
			ph = tcsf_pkg::PH_FINAL;
		end
	end

	// byte select and next phase
	always_comb begin
		phase_d         = ph;
		digit_d         = digit_q;
		seen_d          = seen_q;
		job_pop         = 1'b0;
		out_d.last_of_run = 1'b0;
		out_d.out_byte  = job.final_byte;
		unique case (ph)
			tcsf_pkg::PH_DIGIT: begin
				if ((dig == 4'd0) && !seen_q && !last_digit) begin
					out_d.out_byte = tcsf_pkg::CHAR_SPACE;
				end else begin
					out_d.out_byte = tcsf_pkg::CHAR_ZERO + {4'd0, dig};
				end
				seen_d = seen_q || (dig != 4'd0);
				if (last_digit) begin
					phase_d = tcsf_pkg::PH_TAB;
					digit_d = '0;
				end else begin
					digit_d = digit_q + DW'(1);
				end
			end
			tcsf_pkg::PH_TAB: begin
				out_d.out_byte = tcsf_pkg::TAB_BYTE;
				phase_d        = tcsf_pkg::PH_M;
			end
			tcsf_pkg::PH_M: begin
				out_d.out_byte = tcsf_pkg::CHAR_M;
				phase_d        = tcsf_pkg::PH_DASH;
			end
			tcsf_pkg::PH_DASH: begin
				out_d.out_byte = tcsf_pkg::CHAR_DASH;
				phase_d        = tcsf_pkg::PH_CARET;
			end
			tcsf_pkg::PH_CARET: begin
				out_d.out_byte = tcsf_pkg::CHAR_CARET;
				phase_d        = tcsf_pkg::PH_DOLLAR;
			end
			tcsf_pkg::PH_DOLLAR: begin
				out_d.out_byte = tcsf_pkg::CHAR_DOLLAR;
				phase_d        = tcsf_pkg::PH_FINAL;
			end
			tcsf_pkg::PH_FINAL: begin
				out_d.out_byte    = job.final_byte;
				out_d.last_of_run = 1'b1;
				phase_d           = tcsf_pkg::PH_DIGIT;
				digit_d           = '0;
				seen_d            = 1'b0;
				job_pop           = advance;
			end
			default: begin
				phase_d = tcsf_pkg::PH_DIGIT;
				digit_d = '0;
				seen_d  = 1'b0;
			end
		endcase
	end

	// phase state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tcsf_pkg::PH_DIGIT;
			digit_q <= '0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			digit_q <= digit_d;
			seen_q  <= seen_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= out_d;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

### rtl/core/text_cat_stream_filter_core.sv
// ----------------------------------------------------------------------------
// text_cat_stream_filter_core
// Byte stream filter with line numbering, blank line squeezing and visible
// notation for tabs, line ends and nonprinting bytes.
// ----------------------------------------------------------------------------
// Each input byte yields zero to NUMBER_DIGITS + 5 result bytes, the last one
// flagged with last_of_run. The emitter produces one result byte per cycle
// while the result side takes them; a plain byte expands to one result byte,
// a numbered line start to NUMBER_DIGITS + 2, and a squeezed newline never
// reaches the emitter. The classifier takes a new byte every cycle while the
// two-entry job queue between it and the emitter has room, so full rises only
// behind an expansion or a stalled result side. There is no clearing pass
// after reset. Options are to be written through wr_en/wr_index/wr_data while
// the block is idle; the block itself does not enforce this.
module text_cat_stream_filter_core #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         wr_en,
	input  logic [tcsf_pkg::REG_IDX_W-1:0] wr_index,
	input  logic                         wr_data,
	// input side
	input  logic                         push,
	output logic                         full,
	input  tcsf_pkg::in_item_t           item,
	// result side
	input  logic                         pop,
	output logic                         empty,
	output tcsf_pkg::out_item_t          result
);

	localparam int QUEUE_DEPTH = 2;
	localparam int BCD_W       = 4 * NUMBER_DIGITS;
	localparam int JOB_W       = $bits(tcsf_pkg::job_t) + BCD_W;

	tcsf_pkg::cfg_t   cfg_q;
	logic             accept;
	logic             q_push;
	logic             q_pop;
	logic             q_empty;
	logic             q_full;
	tcsf_pkg::job_t   f_job;
	logic [BCD_W-1:0] f_bcd;
	logic [JOB_W-1:0] q_rd_data;
	tcsf_pkg::job_t   b_job;
	logic [BCD_W-1:0] b_bcd;

	// option registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				tcsf_pkg::REG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= wr_data;
				tcsf_pkg::REG_NUMBER_ALL:       cfg_q.number_all       <= wr_data;
				tcsf_pkg::REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= wr_data;
				tcsf_pkg::REG_SHOW_ENDS:        cfg_q.show_ends        <= wr_data;
				tcsf_pkg::REG_SHOW_TABS:        cfg_q.show_tabs        <= wr_data;
				tcsf_pkg::REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	// classifier
	tcsf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item),
		.accept  (accept),
		.job_push(q_push),
		.job     (f_job),
		.job_bcd (f_bcd)
	);

	// job queue
	tcsf_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_data({f_job, f_bcd}),
		.rd     (q_pop),
		.rd_data(q_rd_data),
		.q_empty(q_empty),
		.q_full (q_full)
	);

	assign b_job = q_rd_data[JOB_W-1:BCD_W];
	assign b_bcd = q_rd_data[BCD_W-1:0];

	// emitter
	tcsf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!q_empty),
		.job      (b_job),
		.job_bcd  (b_bcd),
		.job_pop  (q_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	// emitter retires a job only from a filled queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job retired from empty queue");

	// a retire without a new job frees a queue slot
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_push) |=> !q_full)
		else $error("queue still full after retire");

	// a waiting result always ends a run once its job is retired
	a_retire_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (!empty && result.last_of_run))
		else $error("retired job did not end with a last byte");

endmodule
